// ===== sv/nonanticipative_branch_select_core_macros.svh =====
// Assertion macros used by the RTL of the branch selector (included by nbsc_ctrl).
`ifndef NONANTICIPATIVE_BRANCH_SELECT_CORE_MACROS_SVH
`define NONANTICIPATIVE_BRANCH_SELECT_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define NBSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nbsc implication check failed");
// Next-cycle implication.
`define NBSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nbsc next-cycle check failed");
`else
`define NBSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NBSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/nbsc_pkg.sv =====
`timescale 1ns / 1ps
package nbsc_pkg;

    localparam int VALUE_W = 32;
    localparam int SUM_W   = 48;
    localparam int CFG_W   = 31;
    localparam int IDX_REG_W = 3;

    localparam logic [IDX_REG_W-1:0] CFG_INTEGER_FIRST = 3'd0;
    localparam logic [IDX_REG_W-1:0] CFG_DEV_THRESHOLD = 3'd1;
    localparam logic [IDX_REG_W-1:0] CFG_CONT_OFFSET   = 3'd2;
    localparam logic [IDX_REG_W-1:0] CFG_COLUMN_COUNT  = 3'd3;
    localparam logic [IDX_REG_W-1:0] CFG_SCENARIO_CNT  = 3'd4;

    localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_MUL,
        ST_WR,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_SCAN_CHK,
        ST_FIN_RD,
        ST_FIN_A,
        ST_FIN_B,
        ST_FIN_C
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul;
        logic wr;
        logic scan_init;
        logic next_phase;
        logic scan_ev;
        logic sel_scan;
        logic sel_best;
        logic fin_a;
        logic fin_b;
        logic out_load;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic scan_end;
        logic found;
        logic phase1;
        logic clr_done;
        logic out_full;
    } t_sts;

endpackage

// ===== sv/nonanticipative_branch_select_core.sv =====
`timescale 1ns / 1ps
// Nonanticipativity branching selector. Primal values arrive scenario-major in Q16.16, one
// column per transfer; for each column the block keeps a probability-weighted sum (the
// reference value) and the largest and smallest value across scenarios. A transfer with
// tlast set closes the load: the columns are scanned for the largest range above the
// threshold, first over the leading originally integer columns when the integer-first mode
// is on and then, if nothing qualified, over all columns. One result transfer follows,
// giving the column, its reference value, the down and up split points, the range and the
// feasibility of both branches; found is low and every other field zero when no column
// qualified.
// Timing: each input transfer passes through the read-modify-write of the column memories
// (read, multiply, write back), and no new transfer is taken before it ends. After the
// closing transfer each scan pass reads and evaluates each column visited and then closes
// the pass, at most two passes over column_count columns, before the split points are formed.
// The load state is then cleared by a pass over all MAX_COLUMNS entries, one entry a cycle, during which no input
// transfer is taken; the same pass runs after reset. Configuration writes are taken at any
// time but must only be made while idle.
module nonanticipative_branch_select_core #(
    parameter int MAX_COLUMNS   = 256,
    parameter int MAX_SCENARIOS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // Configuration write port
    input  logic           i_cfg_wr_en,
    input  logic [2:0]     i_cfg_index,
    input  logic [30:0]    i_cfg_wdata,
    // Input stream
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // [31:0] primal_value, [48:32] scenario_weight, [80:49] node_lower,
    // [112:81] node_upper, [119:113] zero
    input  logic [119:0]   s_axis_tdata,
    // [0] orig_continuous, [1] core_continuous
    input  logic [1:0]     s_axis_tuser,
    input  logic           s_axis_tlast,
    // Result stream
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // [7:0] chosen_column, [39:8] reference_value, [71:40] down_point,
    // [103:72] up_point, [134:104] max_deviation, [135] up_feasible,
    // [136] down_feasible, [143:137] zero
    output logic [143:0]   m_axis_tdata,
    // [0] found
    output logic           m_axis_tuser
);

    nbsc_pkg::t_cmd cmd;
    nbsc_pkg::t_sts sts;

    logic        found, up_feas, down_feas;
    logic [7:0]  column;
    logic signed [31:0] ref_v, down_v, up_v;
    logic [30:0] maxdev;

    nbsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    nbsc_dp #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .MAX_SCENARIOS (MAX_SCENARIOS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pv        (s_axis_tdata[31:0]),
        .i_weight    (s_axis_tdata[48:32]),
        .i_types     (s_axis_tuser),
        .i_lower     (s_axis_tdata[80:49]),
        .i_upper     (s_axis_tdata[112:81]),
        .i_last      (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_found     (found),
        .o_column    (column),
        .o_ref       (ref_v),
        .o_down      (down_v),
        .o_up        (up_v),
        .o_maxdev    (maxdev),
        .o_up_feas   (up_feas),
        .o_down_feas (down_feas)
    );

    assign m_axis_tdata = {7'd0, down_feas, up_feas, maxdev, up_v, down_v, ref_v, column};
    assign m_axis_tuser = found;

endmodule

// ===== sv/nbsc_ctrl.sv =====
`timescale 1ns / 1ps
`include "nonanticipative_branch_select_core_macros.svh"
module nbsc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  nbsc_pkg::t_sts  i_sts,
    output nbsc_pkg::t_cmd  o_cmd
);

    nbsc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nbsc_pkg::ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            nbsc_pkg::ST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = nbsc_pkg::ST_IDLE;
            end
            nbsc_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = nbsc_pkg::ST_MUL;
                end
            end
            nbsc_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = nbsc_pkg::ST_WR;
            end
            nbsc_pkg::ST_WR: begin
                o_cmd.wr = 1'b1;
                if (i_sts.last) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = nbsc_pkg::ST_SCAN_RD;
                end else begin
                    n_state = nbsc_pkg::ST_IDLE;
                end
            end
            nbsc_pkg::ST_SCAN_RD: begin
                o_cmd.sel_scan = 1'b1;
                n_state = nbsc_pkg::ST_SCAN_EV;
            end
            nbsc_pkg::ST_SCAN_EV: begin
                o_cmd.sel_scan = 1'b1;
                o_cmd.scan_ev = 1'b1;
                n_state = i_sts.scan_end ? nbsc_pkg::ST_SCAN_CHK : nbsc_pkg::ST_SCAN_RD;
            end
            nbsc_pkg::ST_SCAN_CHK: begin
                if (!i_sts.found && !i_sts.phase1) begin
                    o_cmd.next_phase = 1'b1;
                    n_state = nbsc_pkg::ST_SCAN_RD;
                end else begin
                    n_state = nbsc_pkg::ST_FIN_RD;
                end
            end
            nbsc_pkg::ST_FIN_RD: begin
                o_cmd.sel_best = 1'b1;
                n_state = nbsc_pkg::ST_FIN_A;
            end
            nbsc_pkg::ST_FIN_A: begin
                o_cmd.sel_best = 1'b1;
                o_cmd.fin_a = 1'b1;
                n_state = nbsc_pkg::ST_FIN_B;
            end
            nbsc_pkg::ST_FIN_B: begin
                o_cmd.sel_best = 1'b1;
                o_cmd.fin_b = 1'b1;
                n_state = nbsc_pkg::ST_FIN_C;
            end
            nbsc_pkg::ST_FIN_C: begin
                o_cmd.sel_best = 1'b1;
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = nbsc_pkg::ST_CLR;
                end
            end
            default: begin
                n_state = nbsc_pkg::ST_CLR;
            end
        endcase
    end

    `NBSC_ASSERT_IMP(a_out_free, i_clk, i_rst_n, o_cmd.out_load, !i_sts.out_full)
    `NBSC_ASSERT_NXT(a_accept_mul, i_clk, i_rst_n, o_cmd.accept, r_state == nbsc_pkg::ST_MUL)
    `NBSC_ASSERT_IMP(a_scan_order, i_clk, i_rst_n, o_cmd.scan_ev, $past(r_state) == nbsc_pkg::ST_SCAN_RD)

endmodule

// ===== sv/nbsc_dp.sv =====
`timescale 1ns / 1ps
module nbsc_dp #(
    parameter int MAX_COLUMNS   = 256,
    parameter int MAX_SCENARIOS = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [nbsc_pkg::IDX_REG_W-1:0]         i_cfg_index,
    input  logic [nbsc_pkg::CFG_W-1:0]             i_cfg_wdata,
    input  logic signed [nbsc_pkg::VALUE_W-1:0]    i_pv,
    input  logic [16:0]                            i_weight,
    input  logic [1:0]                             i_types,
    input  logic signed [nbsc_pkg::VALUE_W-1:0]    i_lower,
    input  logic signed [nbsc_pkg::VALUE_W-1:0]    i_upper,
    input  logic                                   i_last,
    input  logic                                   i_out_ready,
    input  nbsc_pkg::t_cmd                         i_cmd,
    output nbsc_pkg::t_sts                         o_sts,
    output logic                                   o_out_valid,
    output logic                                   o_found,
    output logic [7:0]                             o_column,
    output logic signed [nbsc_pkg::VALUE_W-1:0]    o_ref,
    output logic signed [nbsc_pkg::VALUE_W-1:0]    o_down,
    output logic signed [nbsc_pkg::VALUE_W-1:0]    o_up,
    output logic [30:0]                            o_maxdev,
    output logic                                   o_up_feas,
    output logic                                   o_down_feas
);

    localparam int IDX_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CNT_W  = $clog2(MAX_COLUMNS + 1) + 1;
    localparam int SIDX_W = (MAX_SCENARIOS > 1) ? $clog2(MAX_SCENARIOS) : 1;
    localparam int SCNT_W = $clog2(MAX_SCENARIOS + 1) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_COLUMNS - 1);

    // Configuration registers
    logic        r_int_first;
    logic [30:0] r_thr, r_off;
    logic [8:0]  r_cfg_cols;
    logic [6:0]  r_cfg_scens;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_first <= 1'b1;
            r_thr       <= 31'd66;
            r_off       <= 31'd66;
            r_cfg_cols  <= 9'd256;
            r_cfg_scens <= 7'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                nbsc_pkg::CFG_INTEGER_FIRST: r_int_first <= i_cfg_wdata[0];
                nbsc_pkg::CFG_DEV_THRESHOLD: r_thr       <= i_cfg_wdata;
                nbsc_pkg::CFG_CONT_OFFSET:   r_off       <= i_cfg_wdata;
                nbsc_pkg::CFG_COLUMN_COUNT:  r_cfg_cols  <= i_cfg_wdata[8:0];
                nbsc_pkg::CFG_SCENARIO_CNT:  r_cfg_scens <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0]  cols;
    logic [SCNT_W-1:0] scens;
    always_comb begin
        if (r_cfg_cols == 9'd0) cols = CNT_W'(1);
        else if (int'(r_cfg_cols) > MAX_COLUMNS) cols = CNT_W'(MAX_COLUMNS);
        else cols = CNT_W'(r_cfg_cols);
        if (r_cfg_scens == 7'd0) scens = SCNT_W'(1);
        else if (int'(r_cfg_scens) > MAX_SCENARIOS) scens = SCNT_W'(MAX_SCENARIOS);
        else scens = SCNT_W'(r_cfg_scens);
    end

    // Column memories
    logic signed [nbsc_pkg::SUM_W-1:0]   mem_sum [MAX_COLUMNS];
    logic signed [nbsc_pkg::VALUE_W-1:0] mem_max [MAX_COLUMNS];
    logic signed [nbsc_pkg::VALUE_W-1:0] mem_min [MAX_COLUMNS];
    logic [1:0]                          mem_ty  [MAX_COLUMNS];
    logic signed [nbsc_pkg::VALUE_W-1:0] mem_lo  [MAX_COLUMNS];
    logic signed [nbsc_pkg::VALUE_W-1:0] mem_hi  [MAX_COLUMNS];

    logic signed [nbsc_pkg::SUM_W-1:0]   r_rd_sum;
    logic signed [nbsc_pkg::VALUE_W-1:0] r_rd_max, r_rd_min, r_rd_lo, r_rd_hi;
    logic [1:0]                          r_rd_ty;

    logic [IDX_W-1:0]  r_col, r_cur, r_j, r_best, r_clr;
    logic [SIDX_W-1:0] r_scen;
    logic [IDX_W-1:0]  cur_col, rd_addr;

    logic signed [nbsc_pkg::VALUE_W-1:0] r_pv, r_lo, r_hi;
    logic [16:0] r_w;
    logic [1:0]  r_ty;
    logic        r_last;
    logic signed [49:0] r_prod;

    assign cur_col = (CNT_W'(r_col) >= cols) ? '0 : r_col;

    always_comb begin
        if (i_cmd.accept) rd_addr = cur_col;
        else if (i_cmd.sel_scan) rd_addr = r_j;
        else if (i_cmd.sel_best) rd_addr = r_best;
        else rd_addr = r_cur;
    end

    // Load arithmetic
    logic signed [50:0] sum_ext;
    logic signed [nbsc_pkg::SUM_W-1:0] sum_sat;
    assign sum_ext = {{3{r_rd_sum[nbsc_pkg::SUM_W-1]}}, r_rd_sum} + {r_prod[49], r_prod};
    always_comb begin
        if (sum_ext > 51'sh0_7FFF_FFFF_FFFF) sum_sat = 48'sh7FFF_FFFF_FFFF;
        else if (sum_ext < -51'sh0_8000_0000_0000) sum_sat = 48'sh8000_0000_0000;
        else sum_sat = sum_ext[nbsc_pkg::SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem_sum[r_cur] <= sum_sat;
            mem_max[r_cur] <= (r_pv > r_rd_max) ? r_pv : r_rd_max;
            mem_min[r_cur] <= (r_pv < r_rd_min) ? r_pv : r_rd_min;
            mem_ty[r_cur]  <= r_ty;
            mem_lo[r_cur]  <= r_lo;
            mem_hi[r_cur]  <= r_hi;
        end else if (i_cmd.clr_step) begin
            mem_sum[r_clr] <= '0;
            mem_max[r_clr] <= nbsc_pkg::VMIN;
            mem_min[r_clr] <= nbsc_pkg::VMAX;
        end
        r_rd_sum <= mem_sum[rd_addr];
        r_rd_max <= mem_max[rd_addr];
        r_rd_min <= mem_min[rd_addr];
        r_rd_ty  <= mem_ty[rd_addr];
        r_rd_lo  <= mem_lo[rd_addr];
        r_rd_hi  <= mem_hi[rd_addr];
    end

    // Item capture and multiply
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pv  <= i_pv;
            r_w   <= i_weight;
            r_ty  <= i_types;
            r_lo  <= i_lower;
            r_hi  <= i_upper;
            r_cur <= cur_col;
        end
        if (i_cmd.mul) begin
            r_prod <= 50'(r_pv * $signed({1'b0, r_w}));
        end
    end

    // Scan evaluation
    logic [31:0] r_maxdev;
    logic        r_found, r_phase1;
    logic signed [32:0] dev_s;
    logic [31:0] dev_u, bar;
    logic        brk, scan_end;
    assign dev_s    = {r_rd_max[31], r_rd_max} - {r_rd_min[31], r_rd_min};
    assign dev_u    = dev_s[32] ? 32'd0 : dev_s[31:0];
    assign bar      = ({1'b0, r_thr} > r_maxdev) ? {1'b0, r_thr} : r_maxdev;
    assign brk      = !r_phase1 && r_rd_ty[0];
    assign scan_end = brk || ((CNT_W'(r_j) + CNT_W'(1)) >= cols);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_j      <= '0;
            r_maxdev <= '0;
            r_found  <= 1'b0;
            r_phase1 <= !r_int_first;
        end else if (i_cmd.next_phase) begin
            r_j      <= '0;
            r_phase1 <= 1'b1;
        end else if (i_cmd.scan_ev) begin
            r_j <= r_j + IDX_W'(1);
            if (!brk && dev_u > bar) begin
                r_maxdev <= dev_u;
                r_best   <= r_j;
                r_found  <= 1'b1;
            end
        end
    end

    // Split points
    logic signed [nbsc_pkg::VALUE_W-1:0] r_ref, r_dn, r_upp, fl, n_dn, n_up;
    logic signed [33:0] dn_ext, up_ext;
    assign fl     = {r_ref[31:16], 16'h0000};
    assign dn_ext = {{2{r_ref[31]}}, r_ref} - {3'b000, r_off};
    assign up_ext = {{2{r_ref[31]}}, r_ref} + {3'b000, r_off};

    always_comb begin
        if (r_rd_ty[1]) begin
            n_dn = (dn_ext < -34'sh0_8000_0000) ? nbsc_pkg::VMIN : dn_ext[31:0];
            n_up = (up_ext > 34'sh0_7FFF_FFFF) ? nbsc_pkg::VMAX : up_ext[31:0];
        end else begin
            n_dn = fl;
            if (fl == r_ref) n_up = fl;
            else if (fl[31:16] == 16'h7FFF) n_up = nbsc_pkg::VMAX;
            else n_up = fl + 32'sh0001_0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_a) r_ref <= r_rd_sum[47:16];
        if (i_cmd.fin_b) begin
            r_dn  <= n_dn;
            r_upp <= n_up;
        end
    end

    // Output register
    logic r_ovalid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            o_found     <= r_found;
            o_column    <= r_found ? 8'(r_best) : 8'd0;
            o_ref       <= r_found ? r_ref : '0;
            o_down      <= r_found ? r_dn : '0;
            o_up        <= r_found ? r_upp : '0;
            o_maxdev    <= !r_found ? 31'd0 : (r_maxdev[31] ? 31'h7FFF_FFFF : r_maxdev[30:0]);
            o_up_feas   <= r_found && (r_upp <= r_rd_hi);
            o_down_feas <= r_found && (r_rd_lo <= r_dn);
        end
    end
    assign o_out_valid = r_ovalid;

    // Load counters and clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_scen <= '0;
            r_clr  <= '0;
            r_last <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_col  <= '0;
            r_scen <= '0;
            r_clr  <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_last <= i_last;
                if ((CNT_W'(cur_col) + CNT_W'(1)) >= cols) begin
                    r_col <= '0;
                    if ((SCNT_W'(r_scen) >= scens) || (SCNT_W'(r_scen) + SCNT_W'(1) >= scens))
                        r_scen <= '0;
                    else
                        r_scen <= r_scen + SIDX_W'(1);
                end else begin
                    r_col <= cur_col + IDX_W'(1);
                    if (SCNT_W'(r_scen) >= scens) r_scen <= '0;
                end
            end
            if (i_cmd.clr_step && r_clr != LAST_IDX) r_clr <= r_clr + IDX_W'(1);
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.scan_end = scan_end;
    assign o_sts.found    = r_found;
    assign o_sts.phase1   = r_phase1;
    assign o_sts.clr_done = (r_clr == LAST_IDX);
    assign o_sts.out_full = r_ovalid && !i_out_ready;

endmodule
